### src/midi_stream_to_smf_track_assert.svh
// Assertion macros shared by the converter modules.
`ifndef MIDI_STREAM_TO_SMF_TRACK_ASSERT_SVH
`define MIDI_STREAM_TO_SMF_TRACK_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define MSTS_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("midi_stream_to_smf_track: assertion failed");

// Next-cycle implication, checked outside reset.
`define MSTS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("midi_stream_to_smf_track: assertion failed");

`endif

### src/msts_pkg.sv
// Package with shared types and constants of the MIDI stream to SMF track converter.
package msts_pkg;

  localparam int INDEX_BITS = 24;
  localparam int SUM_W      = ((INDEX_BITS > 30) ? INDEX_BITS : 30) + 1;
  localparam int CFG_W      = 24;
  localparam int QDEPTH     = 4;
  localparam int QPTR_W     = $clog2(QDEPTH);

  localparam logic [27:0] VLQ_MAX     = 28'hFFF_FFFF;
  localparam logic [7:0]  EVT_SHORT   = 8'h00;
  localparam logic [7:0]  EVT_TEMPO   = 8'h01;
  localparam logic [3:0]  CLASS_SYS   = 4'hF;
  localparam logic [3:0]  CLASS_PROG  = 4'hC;
  localparam logic [3:0]  CLASS_PRESS = 4'hD;
  localparam logic [7:0]  META_PREFIX = 8'hFF;
  localparam logic [7:0]  META_TEMPO  = 8'h51;
  localparam logic [7:0]  META_LEN    = 8'h03;
  localparam logic [7:0]  EOT_DELTA   = 8'h00;
  localparam logic [7:0]  EOT_TYPE    = 8'h2F;
  localparam logic [7:0]  EOT_LEN     = 8'h00;

  typedef enum logic [1:0] {
    KIND_NONE   = 2'd0,
    KIND_TEMPO  = 2'd1,
    KIND_SHORT2 = 2'd2,
    KIND_SHORT3 = 2'd3
  } kind_t;

  // One queued job: the bytes caused by one input word.
  typedef struct packed {
    logic        fin;
    kind_t       kind;
    logic [1:0]  grp;    // number of delta groups minus one
    logic [27:0] delta;
    logic [23:0] evt;
  } job_t;

  // Queue status seen by the input handshake and the back part.
  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

### src/midi_stream_to_smf_track.sv
// Top level of the MIDI stream data chunk to SMF track body converter.
//
//   channel   direction  handshake            payload
//   input     in         in_valid / in_stall  word[31:0], final_word
//   output    out        out_valid/out_stall  out_byte[7:0], last_of_run, track_done
//   config    in         APB write/read       data_words at byte address 0
//
// A word transfer is taken whenever the job queue has room; the front part parses it then.
// The back part sends one byte per cycle while the output is not stalled, with no gap between jobs;
// a word causes up to fourteen bytes, for a tempo event with a four-byte delta followed by end-of-track.
// With an empty queue its job is first written into the queue, then its first byte is registered
// at the output. Reset is synchronous and clears the parser, the queue and out_valid. A stalled
// output holds its byte while the front part takes words until the four-entry queue fills.
module midi_stream_to_smf_track (
  input  logic        clk,
  input  logic        rst,
  // Input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] word,
  input  logic        final_word,
  // Output channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        last_of_run,
  output logic        track_done,
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Chunk size in words; block ends beyond it stop the conversion.
  logic [msts_pkg::CFG_W-1:0] data_words;

  logic             in_accept;
  logic             push;
  logic             pop;
  msts_pkg::job_t   push_job;
  msts_pkg::job_t   head;
  msts_pkg::qstat_t qstat;

  // There is a single register, so every word address within the port
  // selects it; the address bits are not decoded.
  assign pready = 1'b1;
  assign prdata = {{(32 - msts_pkg::CFG_W){1'b0}}, data_words};

  always_ff @(posedge clk) begin
    if (rst) begin
      data_words <= '0;
    end else if (psel && penable && pwrite && pready && (paddr[1:0] == paddr)) begin
      data_words <= pwdata[msts_pkg::CFG_W-1:0];
    end
  end

  // A transfer is taken whenever the queue can hold the job it may cause.
  assign in_stall  = qstat.full;
  assign in_accept = in_valid && !in_stall;

  msts_front u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (in_accept),
    .word       (word),
    .final_word (final_word),
    .data_words (data_words),
    .push       (push),
    .job        (push_job)
  );

  msts_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .stat     (qstat)
  );

  msts_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .stat        (qstat),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .last_of_run (last_of_run),
    .track_done  (track_done)
  );

endmodule

### src/msts_front.sv
// Front part: parses the stream words and queues the byte jobs they cause.
module msts_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  logic [31:0]          word,
  input  logic                 final_word,
  input  logic [msts_pkg::CFG_W-1:0] data_words,
  output logic                 push,
  output msts_pkg::job_t       job
);

  typedef enum logic [7:0] {
    PH_COUNT = 8'b0000_0001,
    PH_TICK  = 8'b0000_0010,
    PH_SIZE  = 8'b0000_0100,
    PH_DELTA = 8'b0000_1000,
    PH_ID    = 8'b0001_0000,
    PH_EVENT = 8'b0010_0000,
    PH_SKIP  = 8'b0100_0000,
    PH_DONE  = 8'b1000_0000
  } phase_t;

  phase_t                        phase, phase_next;
  logic [31:0]                   blocks_left, blocks_left_next;
  logic [msts_pkg::INDEX_BITS-1:0] word_index, word_index_next;
  logic [msts_pkg::INDEX_BITS-1:0] block_end, block_end_next;
  logic [21:0]                   skip_words_left, skip_words_left_next;
  logic [31:0]                   now_ticks, now_ticks_next;
  logic [31:0]                   written_ticks, written_ticks_next;
  logic                          ended, ended_next;

  logic                          work;
  logic                          elem_done;
  logic [msts_pkg::INDEX_BITS-1:0] be_use;
  logic [msts_pkg::INDEX_BITS-1:0] widx_inc;
  logic [msts_pkg::INDEX_BITS-1:0] hdr;
  logic [msts_pkg::SUM_W-1:0]    blk_sum;
  logic [31:0]                   blocks_dec;
  logic [31:0]                   diff;
  logic [27:0]                   sat;
  logic [22:0]                   long_words;

  assign work     = accept && !ended;
  assign widx_inc = word_index + 1'b1;
  assign hdr      = word_index - 1'b1;
  assign blk_sum  = msts_pkg::SUM_W'(hdr) + msts_pkg::SUM_W'(word[31:2]);
  assign blocks_dec = (blocks_left != 32'd0) ? blocks_left - 32'd1 : blocks_left;
  assign diff     = now_ticks - written_ticks;
  assign sat      = (diff > 32'(msts_pkg::VLQ_MAX)) ? msts_pkg::VLQ_MAX : diff[27:0];
  assign long_words = 23'((25'(word[23:0]) + 25'd3) >> 2);

  always_comb begin
    phase_next           = phase;
    blocks_left_next     = blocks_left;
    word_index_next      = word_index;
    block_end_next       = block_end;
    skip_words_left_next = skip_words_left;
    now_ticks_next       = now_ticks;
    written_ticks_next   = written_ticks;
    ended_next           = ended;
    elem_done            = 1'b0;
    be_use               = block_end;
    job.fin              = 1'b0;
    job.kind             = msts_pkg::KIND_NONE;
    job.delta            = sat;
    job.evt              = word[23:0];
    job.grp              = (sat[27:21] != 7'd0) ? 2'd3 :
                           (sat[20:14] != 7'd0) ? 2'd2 :
                           (sat[13:7]  != 7'd0) ? 2'd1 : 2'd0;
    if (work) begin
      word_index_next = widx_inc;
      unique case (phase)
        PH_COUNT: begin
          blocks_left_next = word;
          phase_next = (word == 32'd0) ? PH_DONE : PH_TICK;
        end
        PH_TICK:  phase_next = PH_SIZE;
        PH_SIZE: begin
          if (blk_sum > msts_pkg::SUM_W'(data_words)) begin
            phase_next = PH_DONE;
          end else begin
            block_end_next = blk_sum[msts_pkg::INDEX_BITS-1:0];
            be_use         = blk_sum[msts_pkg::INDEX_BITS-1:0];
            elem_done      = 1'b1;
          end
        end
        PH_DELTA: begin
          now_ticks_next = now_ticks + word;
          phase_next     = PH_ID;
        end
        PH_ID:    phase_next = PH_EVENT;
        PH_EVENT: begin
          if (word[31]) begin
            if (long_words != 23'd0) begin
              skip_words_left_next = 22'(long_words - 23'd1);
              phase_next           = PH_SKIP;
            end else begin
              elem_done = 1'b1;
            end
          end else begin
            elem_done = 1'b1;
            if (word[31:24] == msts_pkg::EVT_TEMPO) begin
              job.kind = msts_pkg::KIND_TEMPO;
            end else if (word[31:24] == msts_pkg::EVT_SHORT &&
                         word[7:4] != msts_pkg::CLASS_SYS) begin
              job.kind = (word[7:4] == msts_pkg::CLASS_PROG ||
                          word[7:4] == msts_pkg::CLASS_PRESS) ?
                         msts_pkg::KIND_SHORT2 : msts_pkg::KIND_SHORT3;
            end
            if (job.kind != msts_pkg::KIND_NONE) begin
              written_ticks_next = now_ticks;
            end
          end
        end
        PH_SKIP: begin
          if (skip_words_left == 22'd0) begin
            elem_done = 1'b1;
          end else begin
            skip_words_left_next = skip_words_left - 22'd1;
          end
        end
        PH_DONE:  phase_next = PH_DONE;
        default:  phase_next = PH_DONE;
      endcase

      // The element ending at this word is complete: pick what follows.
      if (elem_done) begin
        if (widx_inc < be_use) begin
          phase_next = PH_DELTA;
        end else begin
          blocks_left_next = blocks_dec;
          phase_next = (blocks_dec == 32'd0) ? PH_DONE : PH_TICK;
        end
      end

      if (final_word) begin
        job.fin    = 1'b1;
        ended_next = 1'b1;
        phase_next = PH_DONE;
      end
    end
    push = work && (final_word || job.kind != msts_pkg::KIND_NONE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_COUNT;
      blocks_left     <= '0;
      word_index      <= '0;
      block_end       <= '0;
      skip_words_left <= '0;
      now_ticks       <= '0;
      written_ticks   <= '0;
      ended           <= 1'b0;
    end else begin
      phase           <= phase_next;
      blocks_left     <= blocks_left_next;
      word_index      <= word_index_next;
      block_end       <= block_end_next;
      skip_words_left <= skip_words_left_next;
      now_ticks       <= now_ticks_next;
      written_ticks   <= written_ticks_next;
      ended           <= ended_next;
    end
  end

`include "midi_stream_to_smf_track_assert.svh"

  `MSTS_ASSERT_NEXT(a_ended_sticks, clk, rst, ended, ended)
  `MSTS_ASSERT_NOW(a_no_push_after_end, clk, rst, ended, !push)

endmodule

### src/msts_queue.sv
// Short job queue between the parsing front part and the byte serializer.
module msts_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  msts_pkg::job_t   push_job,
  input  logic             pop,
  output msts_pkg::job_t   head,
  output msts_pkg::qstat_t stat
);

  msts_pkg::job_t              slots [msts_pkg::QDEPTH];
  logic [msts_pkg::QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [msts_pkg::QPTR_W:0]   count;

  assign stat.full  = (count == (msts_pkg::QPTR_W+1)'(msts_pkg::QDEPTH));
  assign stat.empty = (count == '0);
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

`include "midi_stream_to_smf_track_assert.svh"

  `MSTS_ASSERT_NOW(a_no_overflow, clk, rst, stat.full, !push)
  `MSTS_ASSERT_NOW(a_no_underflow, clk, rst, stat.empty, !pop)

endmodule

### src/msts_back.sv
// Back part: turns queued jobs into track bytes, one byte per cycle unless the output stalls.
module msts_back (
  input  logic             clk,
  input  logic             rst,
  input  msts_pkg::job_t   head,
  input  msts_pkg::qstat_t stat,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [7:0]       out_byte,
  output logic             last_of_run,
  output logic             track_done
);

  typedef enum logic [2:0] {
    SEG_DELTA = 3'b001,
    SEG_BODY  = 3'b010,
    SEG_END   = 3'b100
  } seg_t;

  seg_t       seg, cur_seg, nxt_seg;
  logic [2:0] idx, cur_idx, nxt_idx;
  logic       started;
  logic       advance;
  logic [7:0] cur_byte;
  logic [2:0] body_last;
  logic       job_last;
  logic       is_eot;
  logic [6:0] group;

  assign advance = !stat.empty && (!out_valid || !out_stall);
  assign pop     = advance && job_last;

  always_comb begin
    if (started) begin
      cur_seg = seg;
      cur_idx = idx;
    end else if (head.kind != msts_pkg::KIND_NONE) begin
      cur_seg = SEG_DELTA;
      cur_idx = {1'b0, head.grp};
    end else begin
      cur_seg = SEG_END;
      cur_idx = 3'd0;
    end

    unique case (head.kind)
      msts_pkg::KIND_TEMPO:  body_last = 3'd5;
      msts_pkg::KIND_SHORT3: body_last = 3'd2;
      default:               body_last = 3'd1;
    endcase

    unique case (cur_idx[1:0])
      2'd0:    group = head.delta[6:0];
      2'd1:    group = head.delta[13:7];
      2'd2:    group = head.delta[20:14];
      default: group = head.delta[27:21];
    endcase

    cur_byte = 8'h00;
    nxt_seg  = cur_seg;
    nxt_idx  = cur_idx + 3'd1;
    unique case (cur_seg)
      SEG_DELTA: begin
        cur_byte = {cur_idx[1:0] != 2'd0, group};
        if (cur_idx[1:0] == 2'd0) begin
          nxt_seg = SEG_BODY;
          nxt_idx = 3'd0;
        end else begin
          nxt_idx = cur_idx - 3'd1;
        end
      end
      SEG_BODY: begin
        if (head.kind == msts_pkg::KIND_TEMPO) begin
          unique case (cur_idx)
            3'd0:    cur_byte = msts_pkg::META_PREFIX;
            3'd1:    cur_byte = msts_pkg::META_TEMPO;
            3'd2:    cur_byte = msts_pkg::META_LEN;
            3'd3:    cur_byte = head.evt[23:16];
            3'd4:    cur_byte = head.evt[15:8];
            default: cur_byte = head.evt[7:0];
          endcase
        end else begin
          unique case (cur_idx)
            3'd0:    cur_byte = head.evt[7:0];
            3'd1:    cur_byte = head.evt[15:8];
            default: cur_byte = head.evt[23:16];
          endcase
        end
        if (cur_idx == body_last) begin
          nxt_seg = SEG_END;
          nxt_idx = 3'd0;
        end
      end
      SEG_END: begin
        unique case (cur_idx[1:0])
          2'd0:    cur_byte = msts_pkg::EOT_DELTA;
          2'd1:    cur_byte = msts_pkg::META_PREFIX;
          2'd2:    cur_byte = msts_pkg::EOT_TYPE;
          default: cur_byte = msts_pkg::EOT_LEN;
        endcase
      end
      default: cur_byte = 8'h00;
    endcase

    is_eot   = (cur_seg == SEG_END) && (cur_idx == 3'd3);
    job_last = is_eot ||
               ((cur_seg == SEG_BODY) && (cur_idx == body_last) && !head.fin);
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_byte    <= cur_byte;
      last_of_run <= job_last;
      track_done  <= is_eot;
      seg         <= nxt_seg;
      idx         <= nxt_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      started   <= 1'b0;
    end else begin
      if (advance) begin
        out_valid <= 1'b1;
        started   <= !job_last;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

`include "midi_stream_to_smf_track_assert.svh"

  `MSTS_ASSERT_NOW(a_done_ends_run, clk, rst, out_valid && track_done, last_of_run)

endmodule

### bench/midi_stream_to_smf_track_tb.sv
// Self-checking testbench for the MIDI stream data chunk to SMF track body converter.
module midi_stream_to_smf_track_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Register map of the configuration port.
  localparam logic [1:0] ADDR_DATA_WORDS = 2'd0;

  // Cycles allowed for the block to settle once no byte is outstanding. A word
  // with no bytes still passes through the front part, so this covers it too.
  localparam int DRAIN_CYCLES = 32;
  // Length of the long receiver hold-off used to fill the job queue.
  localparam int HOLD_CYCLES = 400;
  // Run limit in clock cycles: far beyond the slowest correct run.
  localparam int TIMEOUT_CYCLES = 200000;
  localparam int RANDOM_WORDS_PER_PHASE = 60;

  // Where the converter stands within the data chunk.
  typedef enum logic [7:0] {
    PH_COUNT = 8'b0000_0001,
    PH_TICK  = 8'b0000_0010,
    PH_SIZE  = 8'b0000_0100,
    PH_DELTA = 8'b0000_1000,
    PH_ID    = 8'b0001_0000,
    PH_EVENT = 8'b0010_0000,
    PH_SKIP  = 8'b0100_0000,
    PH_DONE  = 8'b1000_0000
  } chunk_phase_t;

  // One byte of the track body with its flags.
  typedef struct {
    logic [7:0] value;
    logic       last;
    logic       done;
  } track_byte_t;

  // A row of the opening script. Where a row is typed, the bytes its word must
  // cause are given left-aligned in track_bytes, nbytes of them.
  typedef struct packed {
    logic [31:0] chunk_word;
    logic        typed;
    logic [3:0]  nbytes;
    logic [55:0] track_bytes;
  } script_row_t;

  // The opening script: a block count, then one block whose events run
  // through a tempo change, a saturated delta on a running-status message,
  // a program change, a system message that is dropped, an unknown event
  // type and a long event whose parameter words are skipped.
  localparam int SCRIPT_LEN = 23;
  localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
    '{32'hFFFF_FFFF, 1'b1, 4'd0, 56'h0},               // block count, largest
    '{32'hFFFF_FFFF, 1'b0, 4'd0, 56'h0},               // start tick, ignored
    '{32'h0000_005B, 1'b0, 4'd0, 56'h0},               // size: 22 words
    '{32'h0000_0000, 1'b0, 4'd0, 56'h0},               // zero delta
    '{32'h0000_0000, 1'b0, 4'd0, 56'h0},
    '{32'h0112_3456, 1'b1, 4'd7, 56'h00FF_5103_1234_56}, // tempo
    '{32'hFFFF_FFFF, 1'b0, 4'd0, 56'h0},               // delta past 28 bits
    '{32'hFFFF_FFFF, 1'b0, 4'd0, 56'h0},
    '{32'h007F_0045, 1'b1, 4'd7, 56'hFFFF_FF7F_4500_7F}, // running status
    '{32'h0000_007F, 1'b0, 4'd0, 56'h0},
    '{32'h1234_5678, 1'b0, 4'd0, 56'h0},
    '{32'h0000_AAC3, 1'b1, 4'd3, 56'h7FC3_AA00_0000_00}, // program change
    '{32'h0000_0080, 1'b0, 4'd0, 56'h0},
    '{32'h0000_0000, 1'b0, 4'd0, 56'h0},
    '{32'h0011_22F7, 1'b1, 4'd0, 56'h0},               // system message
    '{32'h0000_0005, 1'b0, 4'd0, 56'h0},
    '{32'h0000_0000, 1'b0, 4'd0, 56'h0},
    '{32'h02FF_FFFF, 1'b0, 4'd0, 56'h0},               // unknown type
    '{32'h0000_0000, 1'b0, 4'd0, 56'h0},
    '{32'hFFFF_FFFF, 1'b0, 4'd0, 56'h0},
    '{32'hFE00_0005, 1'b0, 4'd0, 56'h0},               // long event, 5 bytes
    '{32'h0000_0000, 1'b0, 4'd0, 56'h0},               // parameter words
    '{32'hFFFF_FFFF, 1'b0, 4'd0, 56'h0}
  };

  // Clock, reset and the block's ports. Every input holds a known value from
  // time zero on.
  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] word = '0;
  logic        final_word = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_byte;
  logic        last_of_run;
  logic        track_done;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [1:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // Idle percentages of the two sides, set per phase by the main sequence.
  int send_gap_pct = 0;
  int recv_gap_pct = 0;
  // The main sequence bumps hold_req to ask the receiver for a long hold-off;
  // the receiver counts the hold-off itself.
  int hold_req = 0;
  int hold_ack = 0;
  int hold_left = 0;
  int mismatches = 0;

  // Converter state as the predictor keeps it.
  chunk_phase_t                    parse_phase = PH_COUNT;
  logic [31:0]                     blocks_left = '0;
  logic [msts_pkg::INDEX_BITS-1:0] word_index = '0;
  logic [msts_pkg::INDEX_BITS-1:0] block_end = '0;
  logic [21:0]                     skip_left = '0;
  logic [31:0]                     now_ticks = '0;
  logic [31:0]                     written_ticks = '0;
  logic                            track_ended = 1'b0;
  logic [msts_pkg::CFG_W-1:0]      data_words_cfg = '0;

  // Bytes caused by the word most recently offered, and every byte still owed.
  track_byte_t run_bytes[$];
  track_byte_t pending_track_bytes[$];

  midi_stream_to_smf_track uut (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop in case the block hangs on either handshake.
  initial begin
    #(TIMEOUT_CYCLES * 2);
    $display("FAIL midi_stream_to_smf_track");
    $finish;
  end

  // Only the first ten mismatches are spelled out; the rest are just counted.
  function automatic void flag_mismatch(string what, logic [31:0] want, logic [31:0] seen);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch on %s: expected %h, got %h", what, want, seen);
  endfunction

  function automatic void emit(logic [7:0] b);
    run_bytes.push_back('{b, 1'b0, 1'b0});
  endfunction

  // Variable-length delta since the last written event, clamped to 28 bits.
  function automatic void emit_delta();
    logic [31:0] v;
    int groups;
    v = now_ticks - written_ticks;
    if (v > {4'h0, msts_pkg::VLQ_MAX})
      v = {4'h0, msts_pkg::VLQ_MAX};
    groups = 1;
    while (groups < 4 && (v >> (7 * groups)) != 0)
      groups++;
    for (int g = groups - 1; g >= 0; g--)
      emit(8'((v >> (7 * g)) & 32'h7F) | ((g > 0) ? 8'h80 : 8'h00));
    written_ticks = now_ticks;
  endfunction

  // The element ending at the current word is complete: either another event
  // follows in this block, or the block is over.
  function automatic void finish_element();
    logic [msts_pkg::INDEX_BITS-1:0] nxt;
    nxt = word_index + 1'b1;
    if (nxt < block_end) begin
      parse_phase = PH_DELTA;
    end else begin
      if (blocks_left != 0)
        blocks_left--;
      parse_phase = (blocks_left == 0) ? PH_DONE : PH_TICK;
    end
  endfunction

  function automatic void take_event(logic [31:0] e);
    logic [31:0] words;
    logic [3:0]  cls;
    if (e[31]) begin
      // Long event: its parameter words, padded to whole words, are skipped.
      words = ({8'h00, e[23:0]} + 32'd3) >> 2;
      if (words != 0) begin
        skip_left = 22'(words - 1);
        parse_phase = PH_SKIP;
      end else begin
        finish_element();
      end
    end else begin
      if (e[31:24] == msts_pkg::EVT_TEMPO) begin
        emit_delta();
        emit(msts_pkg::META_PREFIX);
        emit(msts_pkg::META_TEMPO);
        emit(msts_pkg::META_LEN);
        emit(e[23:16]);
        emit(e[15:8]);
        emit(e[7:0]);
      end else if (e[31:24] == msts_pkg::EVT_SHORT) begin
        cls = e[7:4];
        if (cls != msts_pkg::CLASS_SYS) begin
          emit_delta();
          emit(e[7:0]);
          emit(e[15:8]);
          if (cls != msts_pkg::CLASS_PROG && cls != msts_pkg::CLASS_PRESS)
            emit(e[23:16]);
        end
      end
      finish_element();
    end
  endfunction

  // Works out the track bytes one chunk word causes and queues them as owed.
  function automatic void convert_word(logic [31:0] w, logic fin);
    logic [msts_pkg::INDEX_BITS-1:0] hdr;
    logic [31:0]                     span;
    run_bytes.delete();
    if (!track_ended) begin
      case (parse_phase)
        PH_COUNT: begin
          blocks_left = w;
          parse_phase = (w == 0) ? PH_DONE : PH_TICK;
        end
        PH_TICK: parse_phase = PH_SIZE;
        PH_SIZE: begin
          // The block ends at the index of its start tick word plus its size
          // in words; one that runs past the chunk stops the conversion.
          hdr = word_index - 1'b1;
          span = 32'(hdr) + (w >> 2);
          if (span > 32'(data_words_cfg)) begin
            parse_phase = PH_DONE;
          end else begin
            block_end = span[msts_pkg::INDEX_BITS-1:0];
            finish_element();
          end
        end
        PH_DELTA: begin
          now_ticks = now_ticks + w;
          parse_phase = PH_ID;
        end
        PH_ID: parse_phase = PH_EVENT;
        PH_EVENT: take_event(w);
        PH_SKIP: begin
          if (skip_left == 0)
            finish_element();
          else
            skip_left--;
        end
        default: ;
      endcase
      word_index = word_index + 1'b1;
      if (fin) begin
        emit(msts_pkg::EOT_DELTA);
        emit(msts_pkg::META_PREFIX);
        emit(msts_pkg::EOT_TYPE);
        emit(msts_pkg::EOT_LEN);
        run_bytes[run_bytes.size() - 1].done = 1'b1;
        track_ended = 1'b1;
        parse_phase = PH_DONE;
      end
      if (run_bytes.size() != 0)
        run_bytes[run_bytes.size() - 1].last = 1'b1;
      foreach (run_bytes[k])
        pending_track_bytes.push_back(run_bytes[k]);
    end
  endfunction

  // Picks the next chunk word from where the converter stands, so that most
  // words form proper blocks and events while their contents stay random.
  function automatic logic [31:0] next_chunk_word();
    logic [31:0] w;
    logic [31:0] room;
    logic [31:0] k;
    int pick;
    w = $urandom();
    pick = $urandom_range(0, 19);
    case (parse_phase)
      PH_SIZE: begin
        // Keep the block inside the chunk; the two low bits are dropped anyway.
        room = 32'(data_words_cfg) - 32'(word_index - 1'b1);
        k = $urandom_range(0, 16);
        if (k > room)
          k = room;
        w = (k << 2) | (w & 32'h3);
      end
      PH_DELTA: begin
        if (pick < 2)
          w = '0;
        else if (pick < 12)
          w = $urandom_range(1, 127);
        else if (pick < 16)
          w = $urandom_range(128, 32'h001F_FFFF);
        else if (pick < 18)
          w = $urandom_range(32'h0020_0000, 32'h0FFF_FFFF);
      end
      PH_EVENT: begin
        if (pick < 8)
          w = {msts_pkg::EVT_SHORT, w[23:0]};
        else if (pick < 12)
          w = {msts_pkg::EVT_TEMPO, w[23:0]};
        else if (pick < 15)
          w = {1'b1, w[30:24], 24'($urandom_range(1, 40))};
        else if (pick == 15)
          w = {1'b1, w[30:24], 24'h0};
        else
          w = {1'b0, 7'($urandom_range(2, 127)), w[23:0]};
      end
      default: ;
    endcase
    return w;
  endfunction

  // Offers one chunk word after a random gap and holds it until the transfer.
  // The bytes it causes are queued when it is offered, ahead of any output.
  task automatic send_word(input logic [31:0] w, input logic fin);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    convert_word(w, fin);
    word <= w;
    final_word <= fin;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
  endtask

  // Lets every owed byte arrive, then leaves the block time to settle.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_track_bytes.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Writes data_words over the configuration port and reads it back. The read
  // data is sampled on the falling edge inside the access cycle.
  task automatic set_data_words(input logic [msts_pkg::CFG_W-1:0] v);
    logic [31:0] got;
    logic        rdy;
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= ADDR_DATA_WORDS;
    pwdata <= 32'(v);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    data_words_cfg = v;
    @(posedge clk);
    psel <= 1'b1;
    @(posedge clk);
    penable <= 1'b1;
    do begin
      @(negedge clk);
      got = prdata;
      rdy = pready;
      @(posedge clk);
    end while (!rdy);
    psel <= 1'b0;
    penable <= 1'b0;
    if (got !== 32'(v))
      flag_mismatch("data_words readback", 32'(v), got);
  endtask

  // Output side: checks each byte transfer against the oldest owed byte, then
  // picks the stall for the next cycle. A requested hold-off, counted down
  // from HOLD_CYCLES, overrides the random stall.
  always @(posedge clk) begin
    track_byte_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_track_bytes.size() == 0) begin
        flag_mismatch("byte with nothing owed", 32'h0, {24'h0, out_byte});
      end else begin
        want = pending_track_bytes.pop_front();
        if (out_byte !== want.value)
          flag_mismatch("out_byte", {24'h0, want.value}, {24'h0, out_byte});
        if (last_of_run !== want.last)
          flag_mismatch("last_of_run", {31'h0, want.last}, {31'h0, last_of_run});
        if (track_done !== want.done)
          flag_mismatch("track_done", {31'h0, want.done}, {31'h0, track_done});
      end
    end
    if (hold_req != hold_ack) begin
      hold_ack = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_gap_pct);
    end
  end

  // Main sequence. Reset is applied once, so the run is a single track: the
  // word marked final comes last and everything after it must be ignored.
  initial begin
    logic [31:0] lag;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Opening script with the largest chunk size, sender idling lightly and
    // the receiver stalling about half the time.
    set_data_words(24'hFF_FFFF);
    send_gap_pct = 22;
    recv_gap_pct = 53;
    for (int i = 0; i < SCRIPT_LEN; i++) begin
      send_word(SCRIPT[i].chunk_word, 1'b0);
      if (SCRIPT[i].typed) begin
        if (run_bytes.size() != int'(SCRIPT[i].nbytes)) begin
          flag_mismatch("byte count of script row", 32'(SCRIPT[i].nbytes),
                        32'(run_bytes.size()));
        end else begin
          foreach (run_bytes[k])
            if (run_bytes[k].value !== SCRIPT[i].track_bytes[55 - 8 * k -: 8])
              flag_mismatch("script byte", {24'h0, SCRIPT[i].track_bytes[55 - 8 * k -: 8]},
                            {24'h0, run_bytes[k].value});
        end
      end
    end

    // Random blocks in three phases: the receiver idles more than the sender,
    // then the other way round, then neither idles. Each phase has its own
    // chunk size, written while the block is idle.
    for (int mode = 0; mode < 3; mode++) begin
      if (mode == 1) begin
        drain();
        set_data_words(24'($urandom_range(4096, 24'hFF_FFFE)));
        send_gap_pct = 53;
        recv_gap_pct = 22;
      end else if (mode == 2) begin
        // A tight chunk size that still leaves room for this phase's blocks.
        drain();
        set_data_words(24'(word_index) + 24'd400);
        send_gap_pct = 0;
        recv_gap_pct = 0;
        // Long receiver hold-off while the sender keeps offering words, so
        // that the job queue fills and the input is stalled.
        hold_req++;
      end
      for (int n = 0; n < RANDOM_WORDS_PER_PHASE; n++)
        send_word(next_chunk_word(), 1'b0);
    end
    // Run on until the next word is an event delta, so that the track can
    // end in the middle of a block.
    while (parse_phase != PH_DELTA)
      send_word(next_chunk_word(), 1'b0);

    // The smallest chunk size; no block header follows, so nothing stops.
    drain();
    set_data_words('0);

    // Last event: a tempo change whose delta lands just past 28 bits, on the
    // word marked final, so it carries the most bytes any word can cause.
    lag = now_ticks - written_ticks;
    send_word(32'h1000_0000 - lag, 1'b0);
    send_word($urandom(), 1'b0);
    send_word({msts_pkg::EVT_TEMPO, 24'($urandom())}, 1'b1);

    // After end-of-track every word is ignored, marked final or not.
    repeat (3) send_word($urandom(), 1'($urandom_range(0, 1)));
    drain();

    if (mismatches == 0)
      $display("PASS midi_stream_to_smf_track");
    else
      $display("FAIL midi_stream_to_smf_track");
    $finish;
  end

endmodule
